// ===== rtl/spuf_pkg.sv =====
`default_nettype none

package spuf_pkg;

    localparam int SIDE_DEF = 32;

    localparam int SITE_W = 10;
    localparam int SIZE_W = 11;
    localparam int KIND_W = 2;
    localparam int DIR_W  = 2;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int DIV_SHIFT = 20;

    localparam logic [KIND_W-1:0] KIND_MERGE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    localparam logic FUNC_CLEAR  = 1'b0;
    localparam logic FUNC_OCCUPY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/site_percolation_union_find.sv =====
`default_nettype none

// Site percolation on a periodic SIDE x SIDE lattice with a union-find store
// (union by size, no path compression). Send func=0 on s_tuser to clear the
// lattice, func=1 with a site index in s_tdata to occupy a site. An occupy
// returns one merge beat (m_tuser=0) for each distinct neighbor cluster
// absorbed, in the order right, left, down, up, then a summary beat
// (m_tuser=1) with the largest cluster size and m_tlast set. A site already
// occupied or outside the lattice returns a single error beat (m_tuser=2).
// The store is one memory of SIDE*SIDE entries with a read and a write port,
// and every link followed costs one memory read. An occupy reads the site,
// then per neighbor reads it and follows its root path a link per read; each
// merge writes the new root size, then the absorbed root's link. Merge,
// summary and error beats may wait on m_tready. A site outside the lattice
// goes straight to its error beat. After reset and after each clear the block
// sweeps all SIDE*SIDE entries of the store, not ready meanwhile.
// A new beat is taken while the last result still waits on m_tready.
module site_percolation_union_find #(
    parameter int SIDE = spuf_pkg::SIDE_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [spuf_pkg::IN_TDATA_W-1:0]     s_tdata,  // site[9:0]
    input  wire logic                                s_tuser,  // func
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [spuf_pkg::OUT_TDATA_W-1:0]    m_tdata,  // merged_size[10:0], largest[21:11]
    output logic      [spuf_pkg::KIND_W-1:0]         m_tuser,  // kind
    output logic                                     m_tlast   // last
);

    localparam int NSITES = SIDE * SIDE;
    localparam int AW     = $clog2(NSITES);
    localparam int CW     = $clog2(SIDE);
    localparam int VW     = $clog2(NSITES + 1);
    localparam int DIV_M  = ((2 ** spuf_pkg::DIV_SHIFT) + SIDE - 1) / SIDE;
    localparam int SW     = spuf_pkg::SIZE_W;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_CHK,
        S_NB,
        S_NBRD,
        S_CMP,
        S_MRG,
        S_MRG2,
        S_SUM,
        S_ERR
    } state_t;

    typedef struct packed {
        logic          occ;
        logic          root;
        logic [VW-1:0] val;
    } entry_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  cnt_reg, cnt_next;
    logic [spuf_pkg::SITE_W-1:0]    site_reg, site_next;
    logic [spuf_pkg::SITE_W-1:0]    q_reg, q_next;
    logic [AW-1:0]                  s1_reg, s1_next;
    logic [CW-1:0]                  col_reg, col_next;
    logic [AW-1:0]                  r1_reg, r1_next;
    logic [AW-1:0]                  r2_reg, r2_next;
    logic [AW-1:0]                  cur_reg, cur_next;
    logic [VW-1:0]                  size1_reg, size1_next;
    logic [VW-1:0]                  size2_reg, size2_next;
    logic [VW-1:0]                  sum_reg, sum_next;
    logic                           lt_reg, lt_next;
    logic [spuf_pkg::DIR_W-1:0]     dir_reg, dir_next;
    logic [SW-1:0]                  largest_reg, largest_next;
    logic                           mvalid_reg, mvalid_next;
    logic [spuf_pkg::KIND_W-1:0]    mkind_reg, mkind_next;
    logic [SW-1:0]                  mmsz_reg, mmsz_next;
    logic [SW-1:0]                  mbig_reg, mbig_next;
    logic                           mlast_reg, mlast_next;

    entry_t                         mem [NSITES];
    entry_t                         rdata_reg;
    logic [AW-1:0]                  raddr;
    logic                           we;
    logic [AW-1:0]                  waddr;
    entry_t                         wdata;

    logic                           in_acc;
    logic                           out_free;
    logic                           in_range;
    logic [spuf_pkg::SITE_W-1:0]    in_site;
    logic [AW-1:0]                  nb;
    logic [31:0]                    rem;
    logic [31:0]                    colv;
    logic [VW-1:0]                  sum_c;

    spuf_nbr #(
        .SIDE (SIDE)
    ) u_nbr (
        .site (s1_reg),
        .col  (col_reg),
        .dir  (dir_reg),
        .nb   (nb)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign in_site  = s_tdata[spuf_pkg::SITE_W-1:0];
    assign in_range = (32'(in_site) < 32'(NSITES));
    assign sum_c    = size1_reg + size2_reg;

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {(spuf_pkg::OUT_TDATA_W - 2 * SW)'(0), mbig_reg, mmsz_reg};

    always_comb
    begin
        rem  = 32'(site_reg) - 32'(q_reg) * 32'(SIDE);
        colv = (rem >= 32'(SIDE)) ? rem - 32'(SIDE) : rem;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        site_next    = site_reg;
        q_next       = q_reg;
        s1_next      = s1_reg;
        col_next     = col_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        cur_next     = cur_reg;
        size1_next   = size1_reg;
        size2_next   = size2_reg;
        sum_next     = sum_reg;
        lt_next      = lt_reg;
        dir_next     = dir_reg;
        largest_next = largest_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mkind_next   = mkind_reg;
        mmsz_next    = mmsz_reg;
        mbig_next    = mbig_reg;
        mlast_next   = mlast_reg;
        raddr        = cur_reg;
        we           = 1'b0;
        waddr        = cnt_reg;
        wdata        = '0;

        case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = cnt_reg;
                cnt_next = cnt_reg + AW'(1);
                if (32'(cnt_reg) == 32'(NSITES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == spuf_pkg::FUNC_CLEAR)
                    begin
                        largest_next = '0;
                        cnt_next     = '0;
                        state_next   = S_CLR;
                    end
                    else if (!in_range)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        site_next  = in_site;
                        s1_next    = AW'(in_site);
                        raddr      = AW'(in_site);
                        q_next     = spuf_pkg::SITE_W'((32'(in_site) * 32'(DIV_M))
                                                       >> spuf_pkg::DIV_SHIFT);
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (rdata_reg.occ)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = s1_reg;
                    wdata      = '{occ: 1'b1, root: 1'b1, val: VW'(1)};
                    r1_next    = s1_reg;
                    size1_next = VW'(1);
                    dir_next   = spuf_pkg::DIR_RIGHT;
                    col_next   = CW'(colv);
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                raddr      = nb;
                cur_next   = nb;
                state_next = S_NBRD;
            end
            S_NBRD:
            begin
                if (!rdata_reg.occ)
                begin
                    dir_next   = dir_reg + spuf_pkg::DIR_W'(1);
                    state_next = (dir_reg == spuf_pkg::DIR_UP) ? S_SUM : S_NB;
                end
                else if (rdata_reg.root)
                begin
                    r2_next    = cur_reg;
                    size2_next = rdata_reg.val;
                    state_next = S_CMP;
                end
                else
                begin
                    raddr    = rdata_reg.val[AW-1:0];
                    cur_next = rdata_reg.val[AW-1:0];
                end
            end
            S_CMP:
            begin
                if (r2_reg == r1_reg)
                begin
                    dir_next   = dir_reg + spuf_pkg::DIR_W'(1);
                    state_next = (dir_reg == spuf_pkg::DIR_UP) ? S_SUM : S_NB;
                end
                else if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mkind_next  = spuf_pkg::KIND_MERGE;
                    mmsz_next   = SW'(size2_reg);
                    mbig_next   = '0;
                    mlast_next  = 1'b0;
                    sum_next    = sum_c;
                    lt_next     = (size1_reg < size2_reg);
                    if (32'(sum_c) > 32'(largest_reg))
                    begin
                        largest_next = SW'(sum_c);
                    end
                    state_next = S_MRG;
                end
            end
            S_MRG:
            begin
                we         = 1'b1;
                waddr      = lt_reg ? r2_reg : r1_reg;
                wdata      = '{occ: 1'b1, root: 1'b1, val: sum_reg};
                state_next = S_MRG2;
            end
            S_MRG2:
            begin
                we         = 1'b1;
                waddr      = lt_reg ? r1_reg : r2_reg;
                wdata      = '{occ: 1'b1, root: 1'b0,
                               val: VW'(lt_reg ? r2_reg : r1_reg)};
                r1_next    = lt_reg ? r2_reg : r1_reg;
                size1_next = sum_reg;
                dir_next   = dir_reg + spuf_pkg::DIR_W'(1);
                state_next = (dir_reg == spuf_pkg::DIR_UP) ? S_SUM : S_NB;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mkind_next  = spuf_pkg::KIND_SUMMARY;
                    mmsz_next   = '0;
                    mbig_next   = largest_reg;
                    mlast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mkind_next  = spuf_pkg::KIND_ERROR;
                    mmsz_next   = '0;
                    mbig_next   = '0;
                    mlast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            cnt_reg     <= '0;
            largest_reg <= '0;
            mvalid_reg  <= 1'b0;
            site_reg    <= '0;
            q_reg       <= '0;
            s1_reg      <= '0;
            col_reg     <= '0;
            r1_reg      <= '0;
            r2_reg      <= '0;
            cur_reg     <= '0;
            size1_reg   <= '0;
            size2_reg   <= '0;
            sum_reg     <= '0;
            lt_reg      <= 1'b0;
            dir_reg     <= '0;
            mkind_reg   <= '0;
            mmsz_reg    <= '0;
            mbig_reg    <= '0;
            mlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            largest_reg <= largest_next;
            mvalid_reg  <= mvalid_next;
            site_reg    <= site_next;
            q_reg       <= q_next;
            s1_reg      <= s1_next;
            col_reg     <= col_next;
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            cur_reg     <= cur_next;
            size1_reg   <= size1_next;
            size2_reg   <= size2_next;
            sum_reg     <= sum_next;
            lt_reg      <= lt_next;
            dir_reg     <= dir_next;
            mkind_reg   <= mkind_next;
            mmsz_reg    <= mmsz_next;
            mbig_reg    <= mbig_next;
            mlast_reg   <= mlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    a_merge_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == spuf_pkg::KIND_MERGE) |-> !m_tlast)
        else $error("merge beat marked last");

    a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == spuf_pkg::KIND_SUMMARY) |-> m_tlast && (mmsz_reg == '0))
        else $error("summary beat malformed");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == spuf_pkg::KIND_ERROR)
        |-> m_tlast && (mmsz_reg == '0) && (mbig_reg == '0))
        else $error("error beat malformed");

    a_clear_largest: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_tuser == spuf_pkg::FUNC_CLEAR) |=> (largest_reg == '0))
        else $error("clear left largest cluster nonzero");

    a_root_size_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (size1_reg != '0) && (size2_reg != '0))
        else $error("zero cluster size at compare");

endmodule

`default_nettype wire

// ===== rtl/spuf_nbr.sv =====
`default_nettype none

module spuf_nbr #(
    parameter int  SIDE   = spuf_pkg::SIDE_DEF,
    localparam int NSITES = SIDE * SIDE,
    localparam int AW     = $clog2(NSITES),
    localparam int CW     = $clog2(SIDE)
) (
    input  wire logic [AW-1:0]               site,
    input  wire logic [CW-1:0]               col,
    input  wire logic [spuf_pkg::DIR_W-1:0]  dir,
    output logic      [AW-1:0]               nb
);

    logic [31:0] s;
    logic [31:0] c;
    logic [31:0] n;

    always_comb
    begin
        s = 32'(site);
        c = 32'(col);
        case (dir)
            spuf_pkg::DIR_RIGHT:
            begin
                n = (c == 32'(SIDE - 1)) ? s + 32'd1 - 32'(SIDE) : s + 32'd1;
            end
            spuf_pkg::DIR_LEFT:
            begin
                n = (c == 32'd0) ? s + 32'(SIDE - 1) : s - 32'd1;
            end
            spuf_pkg::DIR_DOWN:
            begin
                n = (s + 32'(SIDE) >= 32'(NSITES)) ? s + 32'(SIDE) - 32'(NSITES)
                                                    : s + 32'(SIDE);
            end
            default:
            begin
                n = (s >= 32'(SIDE)) ? s - 32'(SIDE) : s + 32'(NSITES - SIDE);
            end
        endcase
        nb = n[AW-1:0];
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_site_percolation_union_find.sv =====
`timescale 1ns / 100ps

module tb_site_percolation_union_find;

    import spuf_pkg::*;

    localparam int SIDE           = SIDE_DEF;
    localparam int NSITES         = SIDE * SIDE;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_ITEMS   = 200;
    localparam int BAND_SITES     = 128;

    typedef struct {
        bit              func;
        bit [SITE_W-1:0] site;
        int              gap;
        bit              drain;
    } lattice_cmd_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] merged_size;
        logic [SIZE_W-1:0] largest;
        logic              last;
    } perc_rec_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    lattice_cmd_t cmd_q[$];
    perc_rec_t    rec_q[$];
    lattice_cmd_t tx_cmd;

    bit           site_occ[NSITES];
    bit           site_is_root[NSITES];
    int unsigned  site_link[NSITES];
    int unsigned  largest_sz;

    int           mismatch_cnt = 0;
    int           tx_idle = 0;
    int           rx_wait = 0;
    bit           rx_calm = 1'b0;
    bit           tx_calm = 1'b0;
    int           quiet_cycles = 0;

    site_percolation_union_find #(
        .SIDE(SIDE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 50)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic int unsigned root_of(input int unsigned s);
        int unsigned steps;
        steps = 0;
        while (!site_is_root[s] && steps < NSITES)
        begin
            s = site_link[s] % NSITES;
            steps++;
        end
        return s;
    endfunction

    function automatic int unsigned nbr_site(input int unsigned s, input logic [DIR_W-1:0] dir);
        int unsigned col;
        col = s % SIDE;
        case (dir)
            DIR_RIGHT: return (col == SIDE - 1) ? s + 1 - SIDE : s + 1;
            DIR_LEFT:  return (col == 0) ? s + SIDE - 1 : s - 1;
            DIR_DOWN:  return (s + SIDE) % NSITES;
            default:   return (s + NSITES - SIDE) % NSITES;
        endcase
    endfunction

    function automatic void push_rec(input logic [KIND_W-1:0] kind, input int unsigned msz,
                                     input int unsigned big, input logic last);
        perc_rec_t r;
        r.kind        = kind;
        r.merged_size = msz[SIZE_W-1:0];
        r.largest     = big[SIZE_W-1:0];
        r.last        = last;
        rec_q.push_back(r);
    endfunction

    function automatic void lattice_step(input lattice_cmd_t c);
        int unsigned s1;
        int unsigned s2;
        int unsigned r1;
        int unsigned r2;
        if (c.func == FUNC_CLEAR)
        begin
            for (int i = 0; i < NSITES; i++)
            begin
                site_occ[i]     = 1'b0;
                site_is_root[i] = 1'b0;
                site_link[i]    = 0;
            end
            largest_sz = 0;
            return;
        end
        s1 = c.site;
        if (s1 >= NSITES || site_occ[s1])
        begin
            push_rec(KIND_ERROR, 0, 0, 1'b1);
            return;
        end
        site_occ[s1]     = 1'b1;
        site_is_root[s1] = 1'b1;
        site_link[s1]    = 1;
        r1 = s1;
        for (int d = 0; d < 4; d++)
        begin
            s2 = nbr_site(s1, d[DIR_W-1:0]);
            if (site_occ[s2])
            begin
                r2 = root_of(s2);
                if (r2 != r1)
                begin
                    push_rec(KIND_MERGE, site_link[r2], 0, 1'b0);
                    if (site_link[r1] < site_link[r2])
                    begin
                        site_link[r2]   += site_link[r1];
                        site_is_root[r1] = 1'b0;
                        site_link[r1]    = r2;
                        r1 = r2;
                    end
                    else
                    begin
                        site_link[r1]   += site_link[r2];
                        site_is_root[r2] = 1'b0;
                        site_link[r2]    = r1;
                    end
                    if (site_link[r1] > largest_sz)
                        largest_sz = site_link[r1] & 32'h7FF;
                end
            end
        end
        push_rec(KIND_SUMMARY, 0, largest_sz, 1'b1);
    endfunction

    task automatic add_cmd(input bit func, input int unsigned site, input bit drain);
        lattice_cmd_t c;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        c.func  = func;
        c.site  = site[SITE_W-1:0];
        c.gap   = tx_calm ? 0 : $urandom_range(0, 4);
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    // sender: hold each beat until taken, then idle for the next command's gap
    always @(posedge clk)
    begin
        logic fire;
        logic nxt_valid;
        if (rst_n)
        begin
            fire      = s_tvalid && s_tready;
            nxt_valid = s_tvalid && !fire;
            if (fire)
                lattice_step(tx_cmd);
            if (!nxt_valid && cmd_q.size() != 0)
            begin
                if (!(cmd_q[0].drain && rec_q.size() != 0))
                begin
                    if (tx_idle < cmd_q[0].gap)
                        tx_idle++;
                    else
                    begin
                        tx_cmd    = cmd_q.pop_front();
                        tx_idle   = 0;
                        nxt_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= {{(IN_TDATA_W - SITE_W){1'b0}}, tx_cmd.site};
            s_tuser  <= tx_cmd.func;
        end
    end

    // receiver: check each result beat against the oldest expected record
    always @(posedge clk)
    begin
        perc_rec_t want;
        logic      nxt_ready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (rec_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = rec_q.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                    if (m_tdata[SIZE_W-1:0] !== want.merged_size)
                        report_mismatch($sformatf("merged_size %0d, want %0d",
                                                  m_tdata[SIZE_W-1:0], want.merged_size));
                    if (m_tdata[2*SIZE_W-1:SIZE_W] !== want.largest)
                        report_mismatch($sformatf("largest %0d, want %0d",
                                                  m_tdata[2*SIZE_W-1:SIZE_W], want.largest));
                    if (m_tdata[OUT_TDATA_W-1:2*SIZE_W] !== '0)
                        report_mismatch("nonzero pad bits in m_tdata");
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", m_tlast, want.last));
                end
                if ($urandom_range(0, 19) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
            end
            nxt_ready = (rx_wait == 0);
            if (rx_wait != 0)
                rx_wait--;
            m_tready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned band_base;
        int unsigned r;
        largest_sz = 0;

        // corner and wrap sites, repeated neighbor root, re-occupy
        add_cmd(FUNC_OCCUPY, 0, 1'b0);
        add_cmd(FUNC_OCCUPY, 0, 1'b0);
        add_cmd(FUNC_OCCUPY, SIDE - 1, 1'b0);
        add_cmd(FUNC_OCCUPY, NSITES - SIDE, 1'b0);
        add_cmd(FUNC_OCCUPY, NSITES - 1, 1'b0);
        add_cmd(FUNC_OCCUPY, NSITES - 1, 1'b0);
        add_cmd(FUNC_CLEAR, NSITES - 1, 1'b0);
        // four-way merge, then join a larger cluster
        add_cmd(FUNC_OCCUPY, 34, 1'b0);
        add_cmd(FUNC_OCCUPY, 32, 1'b0);
        add_cmd(FUNC_OCCUPY, 65, 1'b0);
        add_cmd(FUNC_OCCUPY, 1, 1'b0);
        add_cmd(FUNC_OCCUPY, 33, 1'b1);
        add_cmd(FUNC_OCCUPY, 2, 1'b0);
        add_cmd(FUNC_OCCUPY, 10'h2AA, 1'b0);
        add_cmd(FUNC_OCCUPY, 10'h155, 1'b0);
        add_cmd(FUNC_CLEAR, 10'h155, 1'b1);
        add_cmd(FUNC_OCCUPY, 5, 1'b0);
        add_cmd(FUNC_OCCUPY, 5, 1'b0);
        add_cmd(FUNC_OCCUPY, 6, 1'b0);

        band_base = $urandom_range(0, NSITES - 1);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                add_cmd(FUNC_CLEAR, $urandom_range(0, NSITES - 1), 1'b0);
                band_base = $urandom_range(0, NSITES - 1);
            end
            else if (r < 78)
                add_cmd(FUNC_OCCUPY, (band_base + $urandom_range(0, BAND_SITES - 1)) % NSITES,
                        $urandom_range(0, 29) == 0);
            else
                add_cmd(FUNC_OCCUPY, $urandom_range(0, NSITES - 1), 1'b0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (rec_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
